/* sv/n2r_pkg.sv */
// Shared types and constants for the NV21 to RGB converter.
package n2r_pkg;

  localparam int DEF_MAX_WIDTH  = 320;
  localparam int DEF_MAX_HEIGHT = 240;

  localparam int ROW_W = 8;
  localparam int COL_W = 9;
  localparam int PIX_W = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 1'b1;

  localparam logic [COL_W-1:0] RESET_WIDTH  = 9'd320;
  localparam logic [ROW_W-1:0] RESET_HEIGHT = 8'd240;

  // BT.601 coefficients in Q10
  localparam int CY  = 1192;
  localparam int CRV = 1634;
  localparam int CGV = 833;
  localparam int CGU = 400;
  localparam int CBU = 2066;
  localparam int Q_SHIFT  = 10;
  localparam int SUM_W    = 21;
  localparam int Y_FLOOR  = 16;
  localparam int C_OFFSET = 128;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] frame_byte;
    logic             frame_start;
  } byte_t;

  typedef struct packed {
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_col;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             run_last;
    logic             frame_last;
  } pixel_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] u;
    logic             last;
  } job_t;

endpackage

/* sv/n2r_if.sv */
// Handshake channel interfaces for bytes, pixels and register writes.
interface n2r_byte_if import n2r_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface n2r_pixel_if import n2r_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface n2r_cfg_if import n2r_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/n2r_ctrl.sv */
// Byte position tracking, luma write requests, block jobs and register file.
module n2r_ctrl import n2r_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int LumaDepth = MAX_WIDTH * MAX_HEIGHT,
  localparam int AddrW     = $clog2(LumaDepth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  n2r_byte_if.sink         byte_i,
  n2r_cfg_if.sink          cfg_i,
  output logic             job_valid_o,
  output job_t             job_o,
  output logic [AddrW-1:0] job_addr_o,
  input  logic             job_ready_i,
  output logic             lwr_en_o,
  output logic [AddrW-1:0] lwr_addr_o,
  output logic [PIX_W-1:0] lwr_data_o,
  output logic [COL_W-1:0] width_o
);

  localparam int PosW     = AddrW + 1;
  localparam int CntW     = $clog2(PosW + 1);
  localparam int MaxWEven = MAX_WIDTH - (MAX_WIDTH % 2);
  localparam int MaxHEven = MAX_HEIGHT - (MAX_HEIGHT % 2);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIX  = 2'd3;

  logic [COL_W-1:0] width_q;
  logic [ROW_W-1:0] height_q;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [16:0]      plane_prod;
  logic [PosW-1:0]  plane;
  logic [PosW-1:0]  total;

  logic [PosW-1:0]  pos_q;
  logic [PosW-1:0]  pos_eff;
  logic [PosW-1:0]  pos_inc;
  logic [PosW-1:0]  chroma_off;
  logic             is_luma;
  logic             is_v;
  logic             is_u;
  logic             ready;
  logic             accept;
  logic [PIX_W-1:0] held_v_q;

  logic [ROW_W-1:0] blk_row_q;
  logic [COL_W-1:0] blk_col_q;
  logic [AddrW-1:0] blk_addr_q;
  logic [COL_W:0]   col_adv;
  logic             col_wrap;

  logic [1:0]       state_q;
  logic [PosW-1:0]  dq_q;
  logic [7:0]       rem_q;
  logic [CntW-1:0]  cnt_q;
  logic [7:0]       divisor;
  logic [8:0]       rem_shift;
  logic             rem_ge;
  logic [16:0]      fix_prod;
  logic [17:0]      fix_addr;

  always_comb begin
    w_eff = {width_q[COL_W-1:1], 1'b0};
    if (w_eff < 9'd2) w_eff = 9'd2;
    if (int'(w_eff) > MaxWEven) w_eff = COL_W'(MaxWEven);
    h_eff = {height_q[ROW_W-1:1], 1'b0};
    if (h_eff < 8'd2) h_eff = 8'd2;
    if (int'(h_eff) > MaxHEven) h_eff = ROW_W'(MaxHEven);
  end

  assign plane_prod = 17'(w_eff) * 17'(h_eff);
  assign plane      = PosW'(plane_prod);
  assign total      = plane + (plane >> 1);

  assign pos_eff    = (byte_i.data.frame_start || pos_q >= total) ? '0 : pos_q;
  assign pos_inc    = pos_eff + PosW'(1);
  assign chroma_off = pos_eff - plane;
  assign is_luma    = pos_eff < plane;
  assign is_v       = !is_luma && !chroma_off[0];
  assign is_u       = !is_luma && chroma_off[0];

  assign ready        = (state_q == ST_RUN) && (is_v || job_ready_i);
  assign byte_i.ready = ready;
  assign accept       = byte_i.valid && ready;
  assign cfg_i.ready  = 1'b1;

  assign col_adv  = {1'b0, blk_col_q} + (COL_W+1)'(2);
  assign col_wrap = col_adv == {1'b0, w_eff};

  assign divisor   = w_eff[COL_W-1:1];
  assign rem_shift = {rem_q, dq_q[PosW-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign fix_prod  = 17'(ROW_W'(dq_q)) * 17'(w_eff);
  assign fix_addr  = {fix_prod, 1'b0} + {9'd0, rem_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      pos_q    <= '0;
      held_v_q <= '0;
      state_q  <= ST_RUN;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          CFG_WIDTH_IDX:  width_q  <= cfg_i.data.wdata;
          CFG_HEIGHT_IDX: height_q <= cfg_i.data.wdata[ROW_W-1:0];
          default:        width_q  <= width_q;
        endcase
      end
      if (accept) begin
        pos_q <= (pos_inc >= total) ? '0 : pos_inc;
        if (is_v) held_v_q <= byte_i.data.frame_byte;
      end
      if (cfg_i.valid) begin
        state_q <= ST_LOAD;
      end else begin
        unique case (state_q)
          ST_LOAD: state_q <= ST_DIV;
          ST_DIV:  if (cnt_q == CntW'(1)) state_q <= ST_FIX;
          ST_FIX:  state_q <= ST_RUN;
          default: state_q <= ST_RUN;
        endcase
      end
    end
  end

  // recompute block index from the held position after a size change
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        dq_q  <= (pos_q >= plane && pos_q < total) ? ((pos_q - plane) >> 1) : '0;
        rem_q <= '0;
        cnt_q <= CntW'(PosW);
      end
      ST_DIV: begin
        rem_q <= rem_ge ? 8'(rem_shift - {1'b0, divisor}) : rem_shift[7:0];
        dq_q  <= {dq_q[PosW-2:0], rem_ge};
        cnt_q <= cnt_q - CntW'(1);
      end
      default: cnt_q <= cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_row_q  <= '0;
      blk_col_q  <= '0;
      blk_addr_q <= '0;
    end else begin
      priority if (state_q == ST_FIX) begin
        blk_row_q  <= ROW_W'(dq_q);
        blk_col_q  <= {rem_q, 1'b0};
        blk_addr_q <= AddrW'(fix_addr);
      end else if (accept && is_v && chroma_off == '0) begin
        blk_row_q  <= '0;
        blk_col_q  <= '0;
        blk_addr_q <= '0;
      end else if (accept && is_u) begin
        if (col_wrap) begin
          blk_row_q  <= blk_row_q + ROW_W'(1);
          blk_col_q  <= '0;
          blk_addr_q <= blk_addr_q + AddrW'(w_eff) + AddrW'(2);
        end else begin
          blk_col_q  <= col_adv[COL_W-1:0];
          blk_addr_q <= blk_addr_q + AddrW'(2);
        end
      end
    end
  end

  assign job_valid_o = accept && is_u;
  assign job_o.row   = blk_row_q;
  assign job_o.col   = blk_col_q;
  assign job_o.v     = held_v_q;
  assign job_o.u     = byte_i.data.frame_byte;
  assign job_o.last  = pos_inc == total;
  assign job_addr_o  = blk_addr_q;

  assign lwr_en_o   = accept && is_luma;
  assign lwr_addr_o = pos_eff[AddrW-1:0];
  assign lwr_data_o = byte_i.data.frame_byte;
  assign width_o    = w_eff;

endmodule

/* sv/n2r_convert.sv */
// Luma store, block read sequencer and BT.601 color pipeline.
module n2r_convert import n2r_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int LumaDepth = MAX_WIDTH * MAX_HEIGHT,
  localparam int AddrW     = $clog2(LumaDepth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  job_t                 job_i,
  input  logic [AddrW-1:0]     job_addr_i,
  output logic                 job_ready_o,
  input  logic                 lwr_en_i,
  input  logic [AddrW-1:0]     lwr_addr_i,
  input  logic [PIX_W-1:0]     lwr_data_i,
  input  logic [COL_W-1:0]     width_i,
  input  logic [OUT_CNT_W-1:0] fifo_count_i,
  output logic                 push_o,
  output pixel_t               push_data_o
);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] u;
    logic             run_last;
    logic             frame_last;
  } meta_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] yy;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] cg;
    logic signed [SUM_W-1:0] cb;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    run_last;
    logic                    frame_last;
  } prod_t;

  function automatic logic [PIX_W-1:0] sat8(input logic signed [SUM_W-1:0] s);
    if (s < 0) return '0;
    if (s[SUM_W-2:Q_SHIFT] > (SUM_W-1-Q_SHIFT)'(255)) return '1;
    return s[Q_SHIFT+PIX_W-1:Q_SHIFT];
  endfunction

  logic [PIX_W-1:0] luma_mem [LumaDepth];

  logic             job_active_q;
  logic [1:0]       k_q;
  job_t             job_q;
  logic [AddrW-1:0] base_q;
  logic [OUT_CNT_W:0] used;
  logic             issue;
  logic [AddrW-1:0] rd_addr;
  meta_t            meta;

  logic             a_valid_q;
  meta_t            a_q;
  logic [PIX_W-1:0] luma_rd_q;

  logic [PIX_W-1:0]        ylim;
  logic signed [8:0]       d9;
  logic signed [8:0]       e9;
  logic signed [SUM_W-1:0] ys;
  logic signed [SUM_W-1:0] dw;
  logic signed [SUM_W-1:0] ew;
  prod_t                   c_d;
  logic                    c_valid_q;
  prod_t                   c_q;

  assign used  = {1'b0, fifo_count_i} + (OUT_CNT_W+1)'(a_valid_q)
               + (OUT_CNT_W+1)'(c_valid_q);
  assign issue = job_active_q && (used < (OUT_CNT_W+1)'(OUT_DEPTH));
  assign job_ready_o = !job_active_q || (issue && k_q == 2'd3);

  assign rd_addr = base_q + (k_q[1] ? AddrW'(width_i) : '0) + AddrW'(k_q[0]);

  assign meta.row        = {job_q.row[ROW_W-2:0], k_q[1]};
  assign meta.col        = job_q.col | COL_W'(k_q[0]);
  assign meta.v          = job_q.v;
  assign meta.u          = job_q.u;
  assign meta.run_last   = k_q == 2'd3;
  assign meta.frame_last = (k_q == 2'd3) && job_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_active_q <= 1'b0;
      k_q          <= '0;
      a_valid_q    <= 1'b0;
      c_valid_q    <= 1'b0;
    end else begin
      a_valid_q <= issue;
      c_valid_q <= a_valid_q;
      if (job_valid_i && job_ready_o) begin
        job_active_q <= 1'b1;
        k_q          <= '0;
      end else if (issue) begin
        k_q <= k_q + 2'd1;
        if (k_q == 2'd3) job_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q  <= job_i;
      base_q <= job_addr_i;
    end
  end

  // read-first: a read and a write on the same edge return the old entry
  always_ff @(posedge clk_i) begin
    if (lwr_en_i) luma_mem[lwr_addr_i] <= lwr_data_i;
    if (issue) begin
      luma_rd_q <= luma_mem[rd_addr];
      a_q       <= meta;
    end
  end

  assign ylim = (luma_rd_q < PIX_W'(Y_FLOOR)) ? '0 : luma_rd_q - PIX_W'(Y_FLOOR);
  assign d9   = $signed({1'b0, a_q.u}) - 9'(C_OFFSET);
  assign e9   = $signed({1'b0, a_q.v}) - 9'(C_OFFSET);
  assign ys   = $signed(SUM_W'(ylim));
  assign dw   = SUM_W'(d9);
  assign ew   = SUM_W'(e9);

  assign c_d.yy         = ys * SUM_W'(CY);
  assign c_d.cr         = ew * SUM_W'(CRV);
  assign c_d.cg         = -(ew * SUM_W'(CGV)) - (dw * SUM_W'(CGU));
  assign c_d.cb         = dw * SUM_W'(CBU);
  assign c_d.row        = a_q.row;
  assign c_d.col        = a_q.col;
  assign c_d.run_last   = a_q.run_last;
  assign c_d.frame_last = a_q.frame_last;

  always_ff @(posedge clk_i) begin
    if (a_valid_q) c_q <= c_d;
  end

  assign push_o                 = c_valid_q;
  assign push_data_o.pixel_row  = c_q.row;
  assign push_data_o.pixel_col  = c_q.col;
  assign push_data_o.red        = sat8(c_q.yy + c_q.cr);
  assign push_data_o.green      = sat8(c_q.yy + c_q.cg);
  assign push_data_o.blue       = sat8(c_q.yy + c_q.cb);
  assign push_data_o.run_last   = c_q.run_last;
  assign push_data_o.frame_last = c_q.frame_last;

endmodule

/* sv/n2r_out_fifo.sv */
// Output pixel queue that decouples the color pipeline from the sink.
module n2r_out_fifo import n2r_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pixel_t               push_data_i,
  output logic [OUT_CNT_W-1:0] count_o,
  n2r_pixel_if.source          pixel_o
);

  pixel_t               fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] count_q;
  logic [OUT_CNT_W-1:0] count_d;
  logic                 pop;

  assign pop     = pixel_o.valid && pixel_o.ready;
  assign count_d = count_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) fifo_mem[wr_ptr_q] <= push_data_i;
  end

  assign pixel_o.valid = count_q != '0;
  assign pixel_o.data  = fifo_mem[rd_ptr_q];
  assign count_o       = count_q;

endmodule

/* sv/nv21_frame_to_rgb.sv */
// A U byte's pixels pass the job register, luma read register, product register and
// output queue, then one pixel a cycle while the queue has room. Throughput: V and luma
// bytes one a cycle, luma only while no block is being read; a U byte waits until the
// previous block has made its four 2x2 reads through the luma memory's single read port.
// Reset: registers 320x240, position and held V zero; the luma store is not cleared.
// A register write stalls bytes while a bit-serial divider rebuilds the block index.
module nv21_frame_to_rgb import n2r_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  n2r_cfg_if.sink     cfg_i,
  n2r_byte_if.sink    byte_i,
  n2r_pixel_if.source pixel_o
);

  localparam int AddrW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic                 job_valid;
  job_t                 job;
  logic [AddrW-1:0]     job_addr;
  logic                 job_ready;
  logic                 lwr_en;
  logic [AddrW-1:0]     lwr_addr;
  logic [PIX_W-1:0]     lwr_data;
  logic [COL_W-1:0]     width;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic                 push;
  pixel_t               push_data;

  n2r_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cfg_i       (cfg_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_addr_o  (job_addr),
    .job_ready_i (job_ready),
    .lwr_en_o    (lwr_en),
    .lwr_addr_o  (lwr_addr),
    .lwr_data_o  (lwr_data),
    .width_o     (width)
  );

  n2r_convert #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_convert (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_addr_i   (job_addr),
    .job_ready_o  (job_ready),
    .lwr_en_i     (lwr_en),
    .lwr_addr_i   (lwr_addr),
    .lwr_data_i   (lwr_data),
    .width_i      (width),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  n2r_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .count_o     (fifo_count),
    .pixel_o     (pixel_o)
  );

endmodule

/* sv/n2r_checker.sv */
// Port-level assertions for the converter and their binding to the top level.
module n2r_checker import n2r_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   pix_valid_i,
  input logic   pix_ready_i,
  input pixel_t pix_data_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pix_data_i))
    else $error("pixel request changed while stalled");

  a_block_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_data_i.run_last |-> pix_data_i.pixel_row[0] && pix_data_i.pixel_col[0])
    else $error("block end not at bottom-right pixel");

  a_frame_end_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_data_i.frame_last |-> pix_data_i.run_last)
    else $error("frame end without block end");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !pix_valid_i)
    else $error("pixel request right after reset");

endmodule

bind nv21_frame_to_rgb n2r_checker u_n2r_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pixel_o.valid),
  .pix_ready_i (pixel_o.ready),
  .pix_data_i  (pixel_o.data)
);
